// ----- design/ntc_pkg.sv -----
// Shared types, type codes and helpers for the numeric type converter.
// No dependencies; every other design file imports this package.
package ntc_pkg;

	typedef enum logic [2:0] {
		T_U8  = 3'd0,
		T_I16 = 3'd1,
		T_I32 = 3'd2,
		T_I64 = 3'd3,
		T_F32 = 3'd4,
		T_F64 = 3'd5
	} typ_t;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_NAN = 2'd2;

	localparam logic CFG_SRC = 1'b0;
	localparam logic CFG_DST = 1'b1;

	// Decoded element: value = mag * 2^eb, or a special class, or a ready result.
	typedef struct packed {
		logic               sgn;
		logic [63:0]        mag;
		logic signed [12:0] eb;
		logic               is_zero;
		logic               is_inf;
		logic               is_nan;
		logic               byp;
		logic [63:0]        byp_val;
		logic [1:0]         byp_st;
		logic               last;
	} dec_t;

	// Normalized element: value = m * 2^(e - 63), m[63] set unless zero.
	typedef struct packed {
		logic               sgn;
		logic [63:0]        m;
		logic signed [12:0] e;
		logic               is_zero;
		logic               is_inf;
		logic               is_nan;
		logic               byp;
		logic [63:0]        byp_val;
		logic [1:0]         byp_st;
		logic               last;
	} nrm_t;

	// Aligned element: kept bits plus guard and sticky for rounding.
	typedef struct packed {
		logic               sgn;
		logic [63:0]        kept;
		logic               guard;
		logic               sticky;
		logic               big;
		logic               sub;
		logic signed [12:0] be;
		logic               is_zero;
		logic               is_inf;
		logic               is_nan;
		logic               byp;
		logic [63:0]        byp_val;
		logic [1:0]         byp_st;
		logic               last;
	} shf_t;

	function automatic typ_t norm_type(input logic [2:0] code);
		typ_t t;
		unique case (code)
			3'd1: t = T_I16;
			3'd2: t = T_I32;
			3'd3: t = T_I64;
			3'd4: t = T_F32;
			3'd5: t = T_F64;
			default: t = T_U8;
		endcase
		return t;
	endfunction

	function automatic logic [63:0] width_mask(input typ_t t);
		logic [63:0] m;
		unique case (t)
			T_U8:    m = 64'h0000_0000_0000_00FF;
			T_I16:   m = 64'h0000_0000_0000_FFFF;
			T_I32:   m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

	function automatic logic is_int(input typ_t t);
		return (t == T_U8) || (t == T_I16) || (t == T_I32) || (t == T_I64);
	endfunction

endpackage

// ----- design/numeric_type_converter.sv -----
// Numeric type converter: five-stage element conversion pipeline.
// Input beats on the s_ group carry the raw source element (src_value in
// s_tdata, right aligned) and the array end marker in s_tlast. Output beats
// on the m_ group carry dest_value in m_tdata[63:0], status in m_tdata[65:64]
// and the end marker in m_tlast; one output beat per input beat, in order.
// The cfg channel writes source_type (index 0) and dest_type (index 1);
// it is always ready and must only be written while the pipeline is empty.
// Throughput is one beat per cycle while m_tready stays high, set by the five
// pipeline registers (decode, leading-zero count, normalize, align, round and
// pack), each taking an item per cycle when its stage advances.
// Each stage advances when its successor has room, so a stalled receiver
// fills the empty stages first and s_tready drops only when all five hold
// a beat; nothing is dropped or repeated. Reset clears every valid bit and
// both type registers to zero (unsigned byte to unsigned byte).
// Depends on ntc_pkg, ntc_decode, ntc_norm and ntc_round.
module numeric_type_converter import ntc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [63:0] src_value
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [63:0] dest_value, [65:64] status, rest zero
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [2:0]  cfg_data
);

	logic [2:0]  source_type_q, dest_type_q;
	logic        valid_s1, valid_s3, valid_s5;
	logic        en_s1, en_s2, en_s3, en_s4, en_s5;
	dec_t        dec_s1;
	nrm_t        nrm_s3;
	logic [63:0] dest_value_s5;
	logic [1:0]  status_s5;
	logic        last_s5;
	logic        valid_s2_seen, valid_s4_seen;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_type_q <= '0;
			dest_type_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SRC: source_type_q <= cfg_data;
				CFG_DST: dest_type_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Track occupancy of the inner stages for the advance chain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2_seen <= 1'b0;
			valid_s4_seen <= 1'b0;
		end else begin
			if (en_s2) valid_s2_seen <= valid_s1;
			if (en_s4) valid_s4_seen <= valid_s3;
		end
	end

	assign en_s5 = !valid_s5 || m_tready;
	assign en_s4 = !valid_s4_seen || en_s5;
	assign en_s3 = !valid_s3 || en_s4;
	assign en_s2 = !valid_s2_seen || en_s3;
	assign en_s1 = !valid_s1 || en_s2;
	assign s_tready = en_s1;

	ntc_decode u_decode (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en_s1),
		.in_valid     (s_tvalid),
		.src_value    (s_tdata),
		.last_element (s_tlast),
		.source_type  (source_type_q),
		.dest_type    (dest_type_q),
		.valid_s1     (valid_s1),
		.dec_s1       (dec_s1)
	);

	ntc_norm u_norm (
		.clk      (clk),
		.arst_n   (arst_n),
		.en_s2    (en_s2),
		.en_s3    (en_s3),
		.valid_s1 (valid_s1),
		.dec_s1   (dec_s1),
		.valid_s3 (valid_s3),
		.nrm_s3   (nrm_s3)
	);

	ntc_round u_round (
		.clk           (clk),
		.arst_n        (arst_n),
		.en_s4         (en_s4),
		.en_s5         (en_s5),
		.dest_type     (dest_type_q),
		.valid_s3      (valid_s3),
		.nrm_s3        (nrm_s3),
		.valid_s5      (valid_s5),
		.dest_value_s5 (dest_value_s5),
		.status_s5     (status_s5),
		.last_s5       (last_s5)
	);

	assign m_tvalid = valid_s5;
	assign m_tdata  = {6'd0, status_s5, dest_value_s5};
	assign m_tlast  = last_s5;

endmodule

// ----- design/ntc_decode.sv -----
// Stage 1: unpack the source element into sign, magnitude and exponent.
// Also resolves pass-through cases directly. Depends on ntc_pkg.
module ntc_decode import ntc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_valid,
	input  logic [63:0] src_value,
	input  logic        last_element,
	input  logic [2:0]  source_type,
	input  logic [2:0]  dest_type,
	output logic        valid_s1,
	output dec_t        dec_s1
);

	typ_t        st, dt;
	dec_t        d;
	logic [63:0] iv;
	logic [7:0]  e8;
	logic [10:0] e11;
	logic        fnan, finf;

	always_comb begin
		st = norm_type(source_type);
		dt = norm_type(dest_type);
		d = '0;
		d.last = last_element;
		iv = '0;
		e8 = src_value[30:23];
		e11 = src_value[62:52];
		fnan = 1'b0;
		finf = 1'b0;
		unique case (st)
			T_F32: begin
				fnan = (e8 == 8'hFF) && (src_value[22:0] != '0);
				finf = (e8 == 8'hFF) && (src_value[22:0] == '0);
				d.sgn = src_value[31];
				d.mag = {40'd0, e8 != 8'd0, src_value[22:0]};
				d.eb = $signed({5'd0, (e8 == 8'd0) ? 8'd1 : e8}) - 13'sd150;
				if (dt == T_F32) begin
					d.byp = 1'b1;
					d.byp_val = {32'd0, src_value[31:0]};
				end else if (dt == T_F64 && fnan) begin
					// quiet the NaN; payload moves up 29 bits
					d.byp = 1'b1;
					d.byp_val = {src_value[31], 11'h7FF, 1'b1, src_value[21:0], 29'd0};
				end
			end
			T_F64: begin
				fnan = (e11 == 11'h7FF) && (src_value[51:0] != '0);
				finf = (e11 == 11'h7FF) && (src_value[51:0] == '0);
				d.sgn = src_value[63];
				d.mag = {11'd0, e11 != 11'd0, src_value[51:0]};
				d.eb = $signed({2'd0, (e11 == 11'd0) ? 11'd1 : e11}) - 13'sd1075;
				if (dt == T_F64) begin
					d.byp = 1'b1;
					d.byp_val = src_value;
				end else if (dt == T_F32 && fnan) begin
					// quiet the NaN; keep the 22 payload bits below the quiet bit
					d.byp = 1'b1;
					d.byp_val = {32'd0, src_value[63], 8'hFF, 1'b1, src_value[50:29]};
				end
			end
			default: begin
				unique case (st)
					T_I16:   iv = {{48{src_value[15]}}, src_value[15:0]};
					T_I32:   iv = {{32{src_value[31]}}, src_value[31:0]};
					T_I64:   iv = src_value;
					default: iv = {56'd0, src_value[7:0]};
				endcase
				d.sgn = iv[63];
				d.mag = iv[63] ? (~iv + 64'd1) : iv;
				d.eb = '0;
				if (is_int(dt)) begin
					d.byp = 1'b1;
					d.byp_val = iv & width_mask(dt);
				end
			end
		endcase
		d.is_nan = fnan;
		d.is_inf = finf;
		d.is_zero = !fnan && !finf && (d.mag == '0);
		d.byp_st = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= d;
		end
	end

endmodule

// ----- design/ntc_norm.sv -----
// Stages 2 and 3: count leading zeros of the magnitude, then shift it up.
// Depends on ntc_pkg.
module ntc_norm import ntc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en_s2,
	input  logic en_s3,
	input  logic valid_s1,
	input  dec_t dec_s1,
	output logic valid_s3,
	output nrm_t nrm_s3
);

	logic       valid_s2;
	dec_t       dec_s2;
	logic [6:0] lz_s2;
	logic [6:0] lz;
	nrm_t       n;

	always_comb begin
		lz = '0;
		for (int i = 0; i < 64; i++) begin
			if (dec_s1.mag[i]) begin
				lz = 7'(63 - i);
			end
		end
	end

	always_comb begin
		n.sgn     = dec_s2.sgn;
		n.m       = dec_s2.mag << lz_s2;
		n.e       = dec_s2.eb + 13'sd63 - $signed({6'd0, lz_s2});
		n.is_zero = dec_s2.is_zero;
		n.is_inf  = dec_s2.is_inf;
		n.is_nan  = dec_s2.is_nan;
		n.byp     = dec_s2.byp;
		n.byp_val = dec_s2.byp_val;
		n.byp_st  = dec_s2.byp_st;
		n.last    = dec_s2.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			dec_s2 <= dec_s1;
			lz_s2 <= lz;
		end
		if (en_s3) begin
			nrm_s3 <= n;
		end
	end

endmodule

// ----- design/ntc_round.sv -----
// Stages 4 and 5: align to the destination, then round, saturate and pack.
// Depends on ntc_pkg.
module ntc_round import ntc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en_s4,
	input  logic        en_s5,
	input  logic [2:0]  dest_type,
	input  logic        valid_s3,
	input  nrm_t        nrm_s3,
	output logic        valid_s5,
	output logic [63:0] dest_value_s5,
	output logic [1:0]  status_s5,
	output logic        last_s5
);

	typ_t               dt;
	logic               valid_s4;
	shf_t               shf_s4;
	shf_t               s;
	logic signed [12:0] be32;
	logic signed [12:0] rf;
	logic [6:0]         r;
	logic [127:0]       ext;

	logic [24:0]        sum24;
	logic [53:0]        sum53;
	logic [34:0]        fw;
	logic [63:0]        dw;
	logic [11:0]        base;
	logic [63:0]        lp, ln, sat_p, sat_n, ires;
	logic               sat;
	logic [63:0]        res;
	logic [1:0]         stat;

	assign dt = norm_type(dest_type);

	// Align: one right shift serves the integer part and both float widths.
	always_comb begin
		be32 = nrm_s3.e + 13'sd127;
		unique case (dt)
			T_F32:   rf = (be32 >= 13'sd1) ? 13'sd40 : (13'sd41 - be32);
			T_F64:   rf = 13'sd11;
			default: rf = 13'sd63 - nrm_s3.e;
		endcase
		if (rf < 13'sd0) begin
			r = '0;
		end else if (rf > 13'sd127) begin
			r = 7'd127;
		end else begin
			r = rf[6:0];
		end
		ext = {nrm_s3.m, 64'd0} >> r;
		s.sgn     = nrm_s3.sgn;
		s.kept    = ext[127:64];
		s.guard   = ext[63];
		s.sticky  = |ext[62:0];
		s.big     = nrm_s3.e > 13'sd63;
		s.sub     = (dt == T_F32) && (be32 < 13'sd1);
		s.be      = (dt == T_F32) ? be32 : (nrm_s3.e + 13'sd1023);
		s.is_zero = nrm_s3.is_zero;
		s.is_inf  = nrm_s3.is_inf;
		s.is_nan  = nrm_s3.is_nan;
		s.byp     = nrm_s3.byp;
		s.byp_val = nrm_s3.byp_val;
		s.byp_st  = nrm_s3.byp_st;
		s.last    = nrm_s3.last;
	end

	// Pack; floats round to nearest even with hidden-bit carry; ints truncate.
	always_comb begin
		sum24 = {1'b0, shf_s4.kept[23:0]} +
			25'(shf_s4.guard & (shf_s4.sticky | shf_s4.kept[0]));
		sum53 = {1'b0, shf_s4.kept[52:0]} +
			54'(shf_s4.guard & (shf_s4.sticky | shf_s4.kept[0]));
		base = (shf_s4.sub || shf_s4.be < 13'sd1) ? 12'd0 : 12'(shf_s4.be - 13'sd1);
		fw = {base, 23'd0} + 35'(sum24);
		dw = {base[10:0], 52'd0} + 64'(sum53);

		unique case (dt)
			T_U8: begin
				lp = 64'd256; ln = 64'd1;
				sat_p = 64'd255; sat_n = 64'd0;
			end
			T_I16: begin
				lp = 64'd32768; ln = 64'd32769;
				sat_p = 64'h7FFF; sat_n = 64'h8000;
			end
			T_I32: begin
				lp = 64'h8000_0000; ln = 64'h8000_0001;
				sat_p = 64'h7FFF_FFFF; sat_n = 64'h8000_0000;
			end
			default: begin
				lp = 64'h8000_0000_0000_0000; ln = 64'h8000_0000_0000_0001;
				sat_p = 64'h7FFF_FFFF_FFFF_FFFF; sat_n = 64'h8000_0000_0000_0000;
			end
		endcase
		sat = shf_s4.is_inf || shf_s4.big ||
			(shf_s4.sgn ? (shf_s4.kept >= ln) : (shf_s4.kept >= lp));
		ires = (shf_s4.sgn ? (~shf_s4.kept + 64'd1) : shf_s4.kept) & width_mask(dt);

		res = '0;
		stat = ST_OK;
		if (shf_s4.byp) begin
			res = shf_s4.byp_val;
			stat = shf_s4.byp_st;
		end else if (dt == T_F32) begin
			if (shf_s4.is_inf) begin
				res = {32'd0, shf_s4.sgn, 8'hFF, 23'd0};
			end else if (shf_s4.is_zero) begin
				res = {32'd0, shf_s4.sgn, 31'd0};
			end else if (fw[34:23] >= 12'd255) begin
				res = {32'd0, shf_s4.sgn, 8'hFF, 23'd0};
				stat = ST_SAT;
			end else begin
				res = {32'd0, shf_s4.sgn, fw[30:0]};
			end
		end else if (dt == T_F64) begin
			if (shf_s4.is_inf) begin
				res = {shf_s4.sgn, 11'h7FF, 52'd0};
			end else if (shf_s4.is_zero) begin
				res = {shf_s4.sgn, 63'd0};
			end else begin
				res = {shf_s4.sgn, dw[62:0]};
			end
		end else begin
			if (shf_s4.is_nan) begin
				stat = ST_NAN;
			end else if (shf_s4.is_zero) begin
				res = '0;
			end else if (sat) begin
				res = shf_s4.sgn ? sat_n : sat_p;
				stat = ST_SAT;
			end else begin
				res = ires;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (en_s4) valid_s4 <= valid_s3;
			if (en_s5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4) begin
			shf_s4 <= s;
		end
		if (en_s5) begin
			dest_value_s5 <= res;
			status_s5 <= stat;
			last_s5 <= shf_s4.last;
		end
	end

endmodule
